// ----- rtl/m2bl_pkg.sv -----
// ----------------------------------------------------------------------------
// m2bl_pkg: shared types and constants of the 2-D bilinear lookup unit
// Map dimensions, operation and region codes, the write and read port
// structs of the storage block and the request of the interpolation unit.
// ----------------------------------------------------------------------------
package m2bl_pkg;

	localparam int MAX_X_POINTS = 16;
	localparam int MAX_Y_POINTS = 16;

	localparam int XW   = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
	localparam int YW   = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
	localparam int NXW  = $clog2(MAX_X_POINTS + 1);
	localparam int NYW  = $clog2(MAX_Y_POINTS + 1);
	localparam int NCELLS = MAX_X_POINTS * MAX_Y_POINTS;
	localparam int CAW  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int SCAN_N = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
	localparam int SCW  = $clog2(SCAN_N + 1);

	localparam int IDXW  = 4;
	localparam int VALW  = 16;
	localparam int CELLW = 10;
	localparam int PTSW  = 5;
	localparam int REGW  = 3;
	localparam int PRODW = 2 * VALW;
	localparam int ACCW  = PRODW + CELLW + 2;

	localparam logic [CELLW-1:0] DUTY_MAX = 10'd1000;

	typedef enum logic [1:0] {
		OP_WR_X    = 2'd0,
		OP_WR_Y    = 2'd1,
		OP_WR_CELL = 2'd2,
		OP_EVAL    = 2'd3
	} op_t;

	typedef enum logic [REGW-1:0] {
		REG_CORNER = 3'd0,
		REG_ROW    = 3'd1,
		REG_COL    = 3'd2,
		REG_INT    = 3'd3,
		REG_NONE   = 3'd4
	} region_t;

	typedef enum logic {
		CFG_X_POINTS = 1'b0,
		CFG_Y_POINTS = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_CLASS,
		S_SCAN,
		S_SETF,
		S_FETCH,
		S_START,
		S_MATH,
		S_RES
	} ctrl_state_t;

	typedef enum logic [1:0] {
		I_IDLE,
		I_MUL,
		I_DIV,
		I_DONE
	} interp_state_t;

	typedef struct packed {
		logic                   x_we;
		logic                   y_we;
		logic                   c_we;
		logic [XW-1:0]          xa;
		logic [YW-1:0]          ya;
		logic [CAW-1:0]         ca;
		logic signed [VALW-1:0] bval;
		logic [CELLW-1:0]       cval;
	} store_wr_t;

	typedef struct packed {
		logic [XW-1:0]  xa;
		logic [YW-1:0]  ya;
		logic [CAW-1:0] ca;
	} store_rd_t;

	typedef struct packed {
		logic             lin;
		logic             neg;
		logic [VALW-1:0]  dxl;
		logic [VALW-1:0]  dxh;
		logic [VALW-1:0]  sx;
		logic [VALW-1:0]  dyl;
		logic [VALW-1:0]  dyh;
		logic [VALW-1:0]  sy;
		logic [CELLW-1:0] q0;
		logic [CELLW-1:0] q1;
		logic [CELLW-1:0] q2;
		logic [CELLW-1:0] q3;
		logic [CELLW-1:0] base;
	} interp_req_t;

	function automatic logic [CAW-1:0] cell_addr(input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		return CAW'(int'(x) * MAX_Y_POINTS + int'(y));
	endfunction

endpackage

// ----- rtl/m2bl_store.sv -----
// ----------------------------------------------------------------------------
// m2bl_store: breakpoint and map memories
// Three synchronous memories with one write and one registered read port.
// ----------------------------------------------------------------------------
module m2bl_store import m2bl_pkg::*; (
	input  logic                   clk,
	input  store_wr_t              wr,
	input  store_rd_t              rd,
	output logic signed [VALW-1:0] x_rdata,
	output logic signed [VALW-1:0] y_rdata,
	output logic [CELLW-1:0]       c_rdata
);

	logic signed [VALW-1:0] xmem [MAX_X_POINTS];
	logic signed [VALW-1:0] ymem [MAX_Y_POINTS];
	logic [CELLW-1:0]       cmem [NCELLS];

	always_ff @(posedge clk) begin
		if (wr.x_we) begin
			xmem[wr.xa] <= wr.bval;
		end
		x_rdata <= xmem[rd.xa];
	end

	always_ff @(posedge clk) begin
		if (wr.y_we) begin
			ymem[wr.ya] <= wr.bval;
		end
		y_rdata <= ymem[rd.ya];
	end

	always_ff @(posedge clk) begin
		if (wr.c_we) begin
			cmem[wr.ca] <= wr.cval;
		end
		c_rdata <= cmem[rd.ca];
	end

endmodule

// ----- rtl/m2bl_interp.sv -----
// ----------------------------------------------------------------------------
// m2bl_interp: interpolation arithmetic
// Accumulates four weighted products with one shared multiplier pair, then
// divides by the cell area with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module m2bl_interp import m2bl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  interp_req_t      req,
	output logic             done,
	output logic [CELLW-1:0] result
);

	localparam logic [3:0] MUL_LAST = 4'd9;
	localparam logic [3:0] DEN_STEP = 4'd8;
	localparam logic [3:0] DIV_LAST = 4'(CELLW - 1);

	interp_state_t st_q, st_d;
	interp_req_t   req_q;
	logic [3:0]         step_q;
	logic [PRODW-1:0]   prod_q;
	logic [ACCW-1:0]    acc_q;
	logic [ACCW-1:0]    den_q;
	logic [CELLW-1:0]   quo_q;

	logic [VALW-1:0]        a_sel, b_sel;
	logic [CELLW-1:0]       q_sel;
	logic [PRODW-1:0]       mul_ab;
	logic [PRODW+CELLW-1:0] term;
	logic                   zero_span;
	logic signed [CELLW+1:0] lin_v;

	assign zero_span = (req_q.sx == '0) || (req_q.sy == '0);

	// Term order: q0 (hi,hi), q1 (lo,hi), q2 (hi,lo), q3 (lo,lo); then the area.
	always_comb begin
		a_sel = req_q.sx;
		b_sel = req_q.sy;
		q_sel = req_q.q0;
		if (step_q < DEN_STEP) begin
			a_sel = step_q[1] ? req_q.dxl : req_q.dxh;
			b_sel = step_q[2] ? req_q.dyl : req_q.dyh;
			case (step_q[2:1])
				2'd0:    q_sel = req_q.q0;
				2'd1:    q_sel = req_q.q1;
				2'd2:    q_sel = req_q.q2;
				default: q_sel = req_q.q3;
			endcase
		end
	end

	assign mul_ab = a_sel * b_sel;
	assign term   = prod_q * q_sel;

	always_comb begin
		st_d = st_q;
		done = 1'b0;
		case (st_q)
			I_IDLE: begin
				if (start) begin
					st_d = ((req.sx == '0) || (req.sy == '0)) ? I_DONE : I_MUL;
				end
			end
			I_MUL: begin
				if (step_q == MUL_LAST) begin
					st_d = I_DIV;
				end
			end
			I_DIV: begin
				if (step_q == DIV_LAST) begin
					st_d = I_DONE;
				end
			end
			I_DONE: begin
				done = 1'b1;
				st_d = I_IDLE;
			end
			default: st_d = I_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= I_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			I_IDLE: begin
				req_q  <= req;
				acc_q  <= '0;
				quo_q  <= '0;
				step_q <= '0;
			end
			I_MUL: begin
				step_q <= (step_q == MUL_LAST) ? 4'd0 : step_q + 4'd1;
				if (step_q == MUL_LAST) begin
					den_q <= ACCW'(prod_q) << (CELLW - 1);
				end else if (step_q[0] == 1'b0) begin
					prod_q <= mul_ab;
				end else begin
					acc_q <= acc_q + ACCW'(term);
				end
			end
			I_DIV: begin
				step_q <= step_q + 4'd1;
				if (acc_q >= den_q) begin
					acc_q <= acc_q - den_q;
					quo_q <= {quo_q[CELLW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[CELLW-2:0], 1'b0};
				end
				den_q <= den_q >> 1;
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	always_comb begin
		lin_v = req_q.neg ? $signed({2'b00, req_q.base}) - $signed({2'b00, quo_q})
		                  : $signed({2'b00, req_q.base}) + $signed({2'b00, quo_q});
		if (zero_span) begin
			result = req_q.base;
		end else if (req_q.lin) begin
			if (lin_v < 0) begin
				result = '0;
			end else if (lin_v > $signed({2'b00, DUTY_MAX})) begin
				result = DUTY_MAX;
			end else begin
				result = lin_v[CELLW-1:0];
			end
		end else begin
			result = (quo_q > DUTY_MAX) ? DUTY_MAX : quo_q;
		end
	end

endmodule

// ----- rtl/m2bl_ctrl.sv -----
// ----------------------------------------------------------------------------
// m2bl_ctrl: lookup sequencer
// Performs writes, reads the axis ends, classifies the command point, scans
// both breakpoint lists for the bracketing segments unless the point is at a
// corner, fetches the cells and hands any interpolation to the arithmetic unit.
// ----------------------------------------------------------------------------
module m2bl_ctrl import m2bl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [IDXW-1:0]        index_x,
	input  logic [IDXW-1:0]        index_y,
	input  logic signed [VALW-1:0] write_value,
	input  logic signed [VALW-1:0] cmd_x,
	input  logic signed [VALW-1:0] cmd_y,
	input  logic [NXW-1:0]         nx,
	input  logic [NYW-1:0]         ny,
	output store_wr_t              wr,
	output store_rd_t              rd,
	input  logic signed [VALW-1:0] x_rdata,
	input  logic signed [VALW-1:0] y_rdata,
	input  logic [CELLW-1:0]       c_rdata,
	output logic                   istart,
	output interp_req_t            ireq,
	input  logic                   idone,
	input  logic [CELLW-1:0]       iresult,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [CELLW-1:0]       res_duty,
	output region_t                res_region
);

	function automatic logic [VALW-1:0] udiff(input logic signed [VALW-1:0] a,
		input logic signed [VALW-1:0] b);
		logic signed [VALW:0] d;
		d = {a[VALW-1], a} - {b[VALW-1], b};
		return d[VALW-1:0];
	endfunction

	ctrl_state_t st_q, st_d;

	logic signed [VALW-1:0] cx_q, cy_q, xf_q, yf_q;
	logic signed [VALW-1:0] xprev_q, yprev_q, x0_q, x1_q, y0_q, y1_q;
	region_t            mode_q;
	logic [XW-1:0]      edge_x_q, xk_q, xa0_q, xa1_q;
	logic [YW-1:0]      edge_y_q, yk_q, ya0_q, ya1_q;
	logic               xfound_q, yfound_q;
	logic [SCW-1:0]     k_q, scan_j_s1, jm1;
	logic               scan_v_s1;
	logic [2:0]         f_q;
	logic               f_v_s1;
	logic [1:0]         f_j_s1;
	logic [CELLW-1:0]   q_q [4];
	logic [CELLW-1:0]   res_duty_q;
	region_t            res_region_q;

	logic               accept;
	op_t                op_c;
	logic [NXW-1:0]     nxm1;
	logic [NYW-1:0]     nym1;
	logic [XW-1:0]      xlast;
	logic [YW-1:0]      ylast;
	logic               lo_x, hi_x, lo_y, hi_y, single_y;
	logic               scan_issue, scan_end, fetch_issue, fetch_end;
	logic               jx_ok, jy_ok, found;
	logic signed [VALW-1:0] cval_s;

	assign accept   = in_valid && in_ready;
	assign op_c     = op_t'(op);
	assign nxm1     = nx - NXW'(1);
	assign nym1     = ny - NYW'(1);
	assign xlast    = nxm1[XW-1:0];
	assign ylast    = nym1[YW-1:0];
	assign single_y = (ny == NYW'(1));

	assign lo_x = cx_q <= xf_q;
	assign hi_x = cx_q >= x_rdata;
	assign lo_y = cy_q <= yf_q;
	assign hi_y = cy_q >= y_rdata;

	assign scan_issue  = (st_q == S_SCAN) && (k_q < SCW'(SCAN_N));
	assign scan_end    = scan_v_s1 && (scan_j_s1 == SCW'(SCAN_N - 1));
	assign fetch_issue = (st_q == S_FETCH) && (f_q < 3'd4);
	assign fetch_end   = f_v_s1 && (f_j_s1 == 2'd3);
	assign jm1         = scan_j_s1 - SCW'(1);
	assign jx_ok = (scan_j_s1 != '0) && (8'(scan_j_s1) < 8'(nx));
	assign jy_ok = (scan_j_s1 != '0) && (8'(scan_j_s1) < 8'(ny));

	always_comb begin
		case (mode_q)
			REG_CORNER: found = 1'b1;
			REG_ROW:    found = xfound_q;
			REG_COL:    found = yfound_q;
			REG_INT:    found = xfound_q && yfound_q;
			default:    found = 1'b0;
		endcase
	end

	// Write port: cell values saturate to the duty range.
	always_comb begin
		cval_s = write_value;
		if (write_value < 0) begin
			cval_s = '0;
		end else if (write_value > $signed({6'd0, DUTY_MAX})) begin
			cval_s = $signed({6'd0, DUTY_MAX});
		end
		wr.x_we = accept && (op_c == OP_WR_X) && (int'(index_x) < MAX_X_POINTS);
		wr.y_we = accept && (op_c == OP_WR_Y) && (int'(index_y) < MAX_Y_POINTS);
		wr.c_we = accept && (op_c == OP_WR_CELL) && (int'(index_x) < MAX_X_POINTS)
		          && (int'(index_y) < MAX_Y_POINTS);
		wr.xa   = XW'(index_x);
		wr.ya   = YW'(index_y);
		wr.ca   = cell_addr(XW'(index_x), YW'(index_y));
		wr.bval = write_value;
		wr.cval = cval_s[CELLW-1:0];
	end

	// Read addresses by state.
	always_comb begin
		rd.xa = '0;
		rd.ya = '0;
		rd.ca = cell_addr(xa0_q, ya0_q);
		case (st_q)
			S_RD1: begin
				rd.xa = xlast;
				rd.ya = ylast;
			end
			S_SCAN: begin
				rd.xa = k_q[XW-1:0];
				rd.ya = k_q[YW-1:0];
			end
			S_FETCH: begin
				case (f_q[1:0])
					2'd0:    rd.ca = cell_addr(xa0_q, ya0_q);
					2'd1:    rd.ca = cell_addr(xa1_q, ya0_q);
					2'd2:    rd.ca = cell_addr(xa0_q, ya1_q);
					default: rd.ca = cell_addr(xa1_q, ya1_q);
				endcase
			end
			default: rd.xa = '0;
		endcase
	end

	// Interpolation request. A linear case is posed as one weighted term over
	// a unit-height cell, with the sign of the slope kept apart so that the
	// quotient truncates toward zero.
	always_comb begin
		logic signed [VALW-1:0] p, p0, p1;
		logic [CELLW-1:0] q1s, mag;
		p   = (mode_q == REG_ROW) ? cx_q : cy_q;
		p0  = (mode_q == REG_ROW) ? x0_q : y0_q;
		p1  = (mode_q == REG_ROW) ? x1_q : y1_q;
		q1s = (mode_q == REG_ROW) ? q_q[1] : q_q[2];
		mag = (q1s < q_q[0]) ? q_q[0] - q1s : q1s - q_q[0];
		ireq.base = q_q[0];
		if (mode_q == REG_INT) begin
			ireq.lin = 1'b0;
			ireq.neg = 1'b0;
			ireq.dxl = udiff(cx_q, x0_q);
			ireq.dxh = udiff(x1_q, cx_q);
			ireq.sx  = udiff(x1_q, x0_q);
			ireq.dyl = udiff(cy_q, y0_q);
			ireq.dyh = udiff(y1_q, cy_q);
			ireq.sy  = udiff(y1_q, y0_q);
			ireq.q0  = q_q[0];
			ireq.q1  = q_q[1];
			ireq.q2  = q_q[2];
			ireq.q3  = q_q[3];
		end else begin
			ireq.lin = 1'b1;
			ireq.neg = q1s < q_q[0];
			ireq.dxl = udiff(p, p0);
			ireq.dxh = '0;
			ireq.sx  = udiff(p1, p0);
			ireq.dyl = '0;
			ireq.dyh = VALW'(1);
			ireq.sy  = VALW'(1);
			ireq.q0  = '0;
			ireq.q1  = mag;
			ireq.q2  = '0;
			ireq.q3  = '0;
		end
	end

	always_comb begin
		st_d      = st_q;
		in_ready  = 1'b0;
		istart    = 1'b0;
		res_valid = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept && (op_c == OP_EVAL)) begin
					st_d = S_RD0;
				end
			end
			S_RD0:   st_d = S_RD1;
			S_RD1:   st_d = S_CLASS;
			S_CLASS: st_d = ((lo_x || hi_x) && (lo_y || hi_y)) ? S_SETF : S_SCAN;
			S_SCAN: begin
				if (scan_end) begin
					st_d = S_SETF;
				end
			end
			S_SETF:  st_d = found ? S_FETCH : S_RES;
			S_FETCH: begin
				if (fetch_end) begin
					st_d = (mode_q == REG_CORNER) ? S_RES : S_START;
				end
			end
			S_START: begin
				istart = 1'b1;
				st_d   = S_MATH;
			end
			S_MATH: begin
				if (idone) begin
					st_d = S_RES;
				end
			end
			S_RES: begin
				res_valid = 1'b1;
				if (res_ready) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			scan_v_s1 <= 1'b0;
			f_v_s1    <= 1'b0;
		end else begin
			st_q      <= st_d;
			scan_v_s1 <= scan_issue;
			f_v_s1    <= fetch_issue;
		end
	end

	always_ff @(posedge clk) begin
		scan_j_s1 <= k_q;
		f_j_s1    <= f_q[1:0];
		if (scan_issue) begin
			k_q <= k_q + SCW'(1);
		end
		if (fetch_issue) begin
			f_q <= f_q + 3'd1;
		end
		if (f_v_s1) begin
			q_q[f_j_s1] <= c_rdata;
		end
		case (st_q)
			S_IDLE: begin
				cx_q <= cmd_x;
				cy_q <= cmd_y;
			end
			S_RD1: begin
				xf_q <= x_rdata;
				yf_q <= y_rdata;
			end
			S_CLASS: begin
				k_q      <= '0;
				xfound_q <= 1'b0;
				yfound_q <= 1'b0;
				// Corner priority: low-low, high-low, low-high, high-high.
				if ((lo_x || hi_x) && (lo_y || hi_y)) begin
					mode_q   <= REG_CORNER;
					edge_x_q <= (lo_x && !(hi_x && !lo_y)) ? '0 : xlast;
					edge_y_q <= (lo_y && !(lo_x && hi_y && !lo_y)) ? '0 : ylast;
					if (lo_x && lo_y) begin
						edge_x_q <= '0;
						edge_y_q <= '0;
					end else if (hi_x && lo_y) begin
						edge_x_q <= xlast;
						edge_y_q <= '0;
					end else if (lo_x && hi_y) begin
						edge_x_q <= '0;
						edge_y_q <= ylast;
					end else begin
						edge_x_q <= xlast;
						edge_y_q <= ylast;
					end
				end else if (lo_y || hi_y || single_y) begin
					mode_q   <= REG_ROW;
					edge_y_q <= (lo_y || single_y) ? '0 : ylast;
				end else if (lo_x || hi_x) begin
					mode_q   <= REG_COL;
					edge_x_q <= lo_x ? '0 : xlast;
				end else begin
					mode_q <= REG_INT;
				end
			end
			S_SCAN: begin
				if (scan_v_s1) begin
					xprev_q <= x_rdata;
					yprev_q <= y_rdata;
					// A later bracketing segment overrides an earlier one.
					if (jx_ok && (cx_q >= xprev_q) && (cx_q <= x_rdata)) begin
						xfound_q <= 1'b1;
						xk_q     <= jm1[XW-1:0];
						x0_q     <= xprev_q;
						x1_q     <= x_rdata;
					end
					if (jy_ok && (cy_q >= yprev_q) && (cy_q <= y_rdata)) begin
						yfound_q <= 1'b1;
						yk_q     <= jm1[YW-1:0];
						y0_q     <= yprev_q;
						y1_q     <= y_rdata;
					end
				end
			end
			S_SETF: begin
				f_q   <= '0;
				xa0_q <= edge_x_q;
				xa1_q <= edge_x_q;
				ya0_q <= edge_y_q;
				ya1_q <= edge_y_q;
				if ((mode_q == REG_ROW) || (mode_q == REG_INT)) begin
					xa0_q <= xk_q;
					xa1_q <= xk_q + XW'(1);
				end
				if ((mode_q == REG_COL) || (mode_q == REG_INT)) begin
					ya0_q <= yk_q;
					ya1_q <= yk_q + YW'(1);
				end
				if (!found) begin
					res_duty_q   <= '0;
					res_region_q <= REG_NONE;
				end
			end
			S_FETCH: begin
				if (fetch_end) begin
					res_duty_q   <= q_q[0];
					res_region_q <= mode_q;
				end
			end
			S_MATH: begin
				if (idone) begin
					res_duty_q   <= iresult;
					res_region_q <= mode_q;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign res_duty   = res_duty_q;
	assign res_region = res_region_q;

endmodule

// ----- rtl/map_2d_bilinear_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// map_2d_bilinear_lookup_unit: 2-D duty map with bilinear interpolation
// Holds X and Y breakpoint lists and a duty map, and evaluates command pairs.
// ----------------------------------------------------------------------------
// Each input word is either a load (X breakpoint, Y breakpoint or map cell)
// or an evaluate request. A load gives no result word. An evaluate request
// gives exactly one result word with the duty value and the region code. The
// breakpoints and cells live in synchronous memories with one read port
// each, so an evaluation walks through them: two reads fetch the ends of both
// axes, a scan over all breakpoint slots finds the bracketing segments (one
// slot per cycle on both axes at once), four reads fetch the cells, and the
// arithmetic unit performs four multiply-accumulates and a restoring
// division. An evaluation inside the map or on an edge runs the breakpoint
// scan and the divider; a corner lookup skips both. The block works on one
// word at a time, but a new word is accepted as soon as the previous result
// sits in the output register. Point counts must be written through the
// configuration port only while the block is idle; the block itself does not
// enforce this. Zero is taken as one point and values above the map size are
// taken as the map size. Memory contents have no reset, so every entry must
// be loaded before it is used.
module map_2d_bilinear_lookup_unit import m2bl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [IDXW-1:0]        index_x,
	input  logic [IDXW-1:0]        index_y,
	input  logic signed [VALW-1:0] write_value,
	input  logic signed [VALW-1:0] cmd_x,
	input  logic signed [VALW-1:0] cmd_y,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [PTSW-1:0]        cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CELLW-1:0]       duty_cycle,
	output logic [REGW-1:0]        region
);

	// Point counts, clamped when written.
	logic [NXW-1:0] nx_q;
	logic [NYW-1:0] ny_q;

	// Output register that decouples the result from the next evaluation.
	logic               out_valid_q;
	logic [CELLW-1:0]   duty_q;
	region_t            region_q;

	store_wr_t          wr;
	store_rd_t          rd;
	logic signed [VALW-1:0] x_rdata, y_rdata;
	logic [CELLW-1:0]   c_rdata;
	interp_req_t        ireq;
	logic               istart, idone;
	logic [CELLW-1:0]   iresult;
	logic               res_valid, res_ready;
	logic [CELLW-1:0]   res_duty;
	region_t            res_region;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= NXW'(1);
			ny_q <= NYW'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_POINTS: begin
					if (cfg_data == '0) begin
						nx_q <= NXW'(1);
					end else if (int'(cfg_data) > MAX_X_POINTS) begin
						nx_q <= NXW'(MAX_X_POINTS);
					end else begin
						nx_q <= NXW'(cfg_data);
					end
				end
				CFG_Y_POINTS: begin
					if (cfg_data == '0) begin
						ny_q <= NYW'(1);
					end else if (int'(cfg_data) > MAX_Y_POINTS) begin
						ny_q <= NYW'(MAX_Y_POINTS);
					end else begin
						ny_q <= NYW'(cfg_data);
					end
				end
				default: nx_q <= nx_q;
			endcase
		end
	end

	// The sequencer may hand over a result when the register is empty or is
	// being emptied in the same cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			duty_q   <= res_duty;
			region_q <= res_region;
		end
	end

	assign out_valid  = out_valid_q;
	assign duty_cycle = duty_q;
	assign region     = region_q;

	m2bl_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.x_rdata (x_rdata),
		.y_rdata (y_rdata),
		.c_rdata (c_rdata)
	);

	m2bl_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (istart),
		.req    (ireq),
		.done   (idone),
		.result (iresult)
	);

	m2bl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.index_x     (index_x),
		.index_y     (index_y),
		.write_value (write_value),
		.cmd_x       (cmd_x),
		.cmd_y       (cmd_y),
		.nx          (nx_q),
		.ny          (ny_q),
		.wr          (wr),
		.rd          (rd),
		.x_rdata     (x_rdata),
		.y_rdata     (y_rdata),
		.c_rdata     (c_rdata),
		.istart      (istart),
		.ireq        (ireq),
		.idone       (idone),
		.iresult     (iresult),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_duty    (res_duty),
		.res_region  (res_region)
	);

endmodule
